// ===== src/ets_pkg.sv =====
// Shared types and constants for the edge trigger search block.
package ets_pkg;

  // Field widths fixed by the item and register formats.
  localparam int unsigned SampleW  = 12;
  localparam int unsigned OffsetW  = 10;
  localparam int unsigned TrigIdxW = 11;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegThreshold   = 2'd0;
  localparam logic [1:0] RegFallingEdge = 2'd1;
  localparam logic [1:0] RegBackOffset  = 2'd2;

  // Reset values of the registers.
  localparam logic [SampleW-1:0] ThresholdRst  = 12'd2048;
  localparam logic [OffsetW-1:0] BackOffsetRst = 10'd64;

  // Input item kinds carried on tuser.
  localparam logic CmdWrite  = 1'b0;
  localparam logic CmdSearch = 1'b1;

  // Search sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_HOLD
  } scan_state_e;

  // Trigger setup shared by the register bank and the sequencer.
  typedef struct packed {
    logic [SampleW-1:0] threshold;
    logic               falling_edge;
    logic [OffsetW-1:0] back_offset;
  } trig_cfg_t;

endpackage

// ===== src/ets_store.sv =====
// Circular sample memory with latest-write pointer and fill count.
module ets_store #(
  parameter int unsigned STORE_DEPTH = 2048
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_en_i,
  input  logic [ets_pkg::SampleW-1:0]        wr_sample_i,
  input  logic                               rd_en_i,
  input  logic [$clog2(STORE_DEPTH)-1:0]     rd_addr_i,
  output logic [ets_pkg::SampleW-1:0]        rd_data_o,
  output logic [$clog2(STORE_DEPTH)-1:0]     latest_o
);

  localparam int unsigned IW = $clog2(STORE_DEPTH);

  logic [ets_pkg::SampleW-1:0] mem [STORE_DEPTH];
  logic [ets_pkg::SampleW-1:0] rd_q;
  logic                        rd_live_q;
  logic [IW-1:0]               latest_q, latest_d;
  logic [IW:0]                 fill_q, fill_d;

  // The pointer advances before each write, wrapping at the store depth.
  always_comb begin
    latest_d = latest_q;
    fill_d   = fill_q;
    if (wr_en_i) begin
      latest_d = (latest_q == IW'(STORE_DEPTH - 1)) ? '0 : latest_q + 1'b1;
      if (fill_q != (IW+1)'(STORE_DEPTH)) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latest_q <= IW'(STORE_DEPTH - 1);
      fill_q   <= '0;
    end else begin
      latest_q <= latest_d;
      fill_q   <= fill_d;
    end
  end

  // Writes fill the store in order from entry zero, so entries at or above the
  // fill count have not been written yet and are masked to zero on read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[latest_d] <= wr_sample_i;
    end
    if (rd_en_i) begin
      rd_q      <= mem[rd_addr_i];
      rd_live_q <= ({1'b0, rd_addr_i} < fill_q);
    end
  end

  assign rd_data_o = rd_live_q ? rd_q : '0;
  assign latest_o  = latest_q;

endmodule

// ===== src/ets_scan.sv =====
// Search sequencer: start index, backward memory walk, crossing test, result register.
module ets_scan #(
  parameter int unsigned STORE_DEPTH = 2048
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ets_pkg::trig_cfg_t                 cfg_i,
  input  logic                               in_valid_i,
  input  logic                               in_command_i,
  output logic                               in_ready_o,
  output logic                               wr_en_o,
  output logic                               rd_en_o,
  output logic [$clog2(STORE_DEPTH)-1:0]     rd_addr_o,
  input  logic [ets_pkg::SampleW-1:0]        rd_data_i,
  input  logic [$clog2(STORE_DEPTH)-1:0]     latest_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ets_pkg::TrigIdxW-1:0]       out_index_o,
  output logic                               out_not_found_o
);

  localparam int unsigned IW   = $clog2(STORE_DEPTH);
  localparam int unsigned OW   = (IW > ets_pkg::OffsetW) ? IW : ets_pkg::OffsetW;
  localparam int unsigned HALF = STORE_DEPTH / 2;

  ets_pkg::scan_state_e state_q, state_d;

  logic [OW-1:0]               off_q, off_d;
  logic [IW-1:0]               start_q, start_d;
  logic [IW-1:0]               rd_addr_q, rd_addr_d;
  logic [IW-1:0]               iss_q, iss_d;
  logic                        data_vld_q;
  logic [IW-1:0]               data_pos_q;
  logic [IW-1:0]               data_idx_q;
  logic [ets_pkg::SampleW-1:0] prev_data_q;
  logic [IW-1:0]               prev_pos_q;
  logic [IW-1:0]               res_pos_q, res_pos_d;
  logic                        res_nf_q, res_nf_d;
  logic                        out_valid_q, out_valid_d;
  logic [IW-1:0]               out_pos_q;
  logic                        out_nf_q;

  logic                        accept;
  logic                        off_big;
  logic [IW-1:0]               off_n;
  logic [IW-1:0]               start_calc;
  logic                        cur_hi, old_hi, hit;
  logic                        scan_data;
  logic                        scan_last;
  logic                        out_free;
  logic                        load_out;
  logic [31:0]                 out_pos_w;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Offset reduction: one subtract of the depth per cycle until it lies below it.
  assign off_big = (32'(off_q) >= 32'(STORE_DEPTH));
  assign off_n   = off_q[IW-1:0];
  assign start_calc = (latest_i >= off_n) ? (latest_i - off_n)
                    : IW'({1'b0, latest_i} + (IW+1)'(STORE_DEPTH) - {1'b0, off_n});

  // Crossing test on the newer sample and the one just read behind it.
  assign cur_hi    = (prev_data_q >= cfg_i.threshold);
  assign old_hi    = (rd_data_i >= cfg_i.threshold);
  assign hit       = cfg_i.falling_edge ? (!cur_hi && old_hi) : (cur_hi && !old_hi);
  assign scan_data = (state_q == ets_pkg::ST_SCAN) && data_vld_q;
  assign scan_last = (data_idx_q == IW'(HALF));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ets_pkg::ST_IDLE: begin
        if (accept && (in_command_i == ets_pkg::CmdSearch)) begin
          state_d = ets_pkg::ST_REDUCE;
        end
      end
      ets_pkg::ST_REDUCE: begin
        if (!off_big) begin
          state_d = ets_pkg::ST_SCAN;
        end
      end
      ets_pkg::ST_SCAN: begin
        if (scan_data && (data_idx_q != '0) && (hit || scan_last)) begin
          state_d = ets_pkg::ST_HOLD;
        end
      end
      ets_pkg::ST_HOLD: begin
        if (out_free) begin
          state_d = ets_pkg::ST_IDLE;
        end
      end
      default: state_d = ets_pkg::ST_IDLE;
    endcase
  end

  // Datapath and handshake outputs.
  always_comb begin
    in_ready_o = 1'b0;
    wr_en_o    = 1'b0;
    rd_en_o    = 1'b0;
    off_d      = off_q;
    start_d    = start_q;
    rd_addr_d  = rd_addr_q;
    iss_d      = iss_q;
    res_pos_d  = res_pos_q;
    res_nf_d   = res_nf_q;
    load_out   = 1'b0;
    unique case (state_q)
      ets_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        wr_en_o    = in_valid_i && (in_command_i == ets_pkg::CmdWrite);
        off_d      = OW'(cfg_i.back_offset);
      end
      ets_pkg::ST_REDUCE: begin
        if (off_big) begin
          off_d = off_q - OW'(STORE_DEPTH);
        end else begin
          start_d   = start_calc;
          rd_addr_d = start_calc;
          iss_d     = '0;
        end
      end
      ets_pkg::ST_SCAN: begin
        rd_en_o   = 1'b1;
        rd_addr_d = (rd_addr_q == '0) ? IW'(STORE_DEPTH - 1) : rd_addr_q - 1'b1;
        iss_d     = iss_q + 1'b1;
        if (scan_data && (data_idx_q != '0)) begin
          res_pos_d = hit ? prev_pos_q : start_q;
          res_nf_d  = !hit;
        end
      end
      ets_pkg::ST_HOLD: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ets_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      data_vld_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      data_vld_q  <= rd_en_o;
    end
  end

  // Payload registers; read tags are registered alongside the memory's read data.
  always_ff @(posedge clk_i) begin
    off_q      <= off_d;
    start_q    <= start_d;
    rd_addr_q  <= rd_addr_d;
    iss_q      <= iss_d;
    res_pos_q  <= res_pos_d;
    res_nf_q   <= res_nf_d;
    data_pos_q <= rd_addr_q;
    data_idx_q <= iss_q;
    if (scan_data) begin
      prev_data_q <= rd_data_i;
      prev_pos_q  <= data_pos_q;
    end
    if (load_out) begin
      out_pos_q <= res_pos_q;
      out_nf_q  <= res_nf_q;
    end
  end

  assign rd_addr_o       = rd_addr_q;
  assign out_pos_w       = 32'(out_pos_q);
  assign out_valid_o     = out_valid_q;
  assign out_index_o     = out_pos_w[ets_pkg::TrigIdxW-1:0];
  assign out_not_found_o = out_nf_q;

endmodule

// ===== src/edge_trigger_search_unit.sv =====
// Top level: register bank, sample store and search sequencer.
//
// Usage: sample and search items arrive on the s_axis group. tuser carries the
// item kind (0 writes the sample in tdata, 1 starts a trigger search). A write
// is stored at the next position of a circular store. A search walks backwards
// from the latest write minus back_offset over half the store and returns one
// item on m_axis: tdata holds the store index of the first threshold crossing,
// tuser is set when none was found and tdata then holds the start index. Writes
// give no result item. A search first subtracts the depth from back_offset
// until it lies below it (no subtraction when STORE_DEPTH exceeds 1023), then
// forms the start index, then walks the memory one entry per cycle through the
// single read port, and then loads the output register. Writes sustain one item
// per cycle; no item is taken during a search. After reset the store reads as
// all zero at once: a fill count masks entries not yet written, so there is no
// clearing pass. When the receiver stalls, the result waits in the output
// register; writes are still taken, and a following search holds its result
// until the register is free.
module edge_trigger_search_unit #(
  parameter int unsigned STORE_DEPTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] sample
  input  logic        s_axis_tuser,   // [0] command
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [10:0] trigger_index
  output logic        m_axis_tuser    // [0] not_found
);

  localparam int unsigned IW = $clog2(STORE_DEPTH);

  ets_pkg::trig_cfg_t                cfg_q;
  logic                              cfg_wr;
  logic                              wr_en;
  logic                              rd_en;
  logic [IW-1:0]                     rd_addr;
  logic [ets_pkg::SampleW-1:0]       rd_data;
  logic [IW-1:0]                     latest;
  logic [ets_pkg::TrigIdxW-1:0]      out_index;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Register writes; addresses beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold    <= ets_pkg::ThresholdRst;
      cfg_q.falling_edge <= 1'b0;
      cfg_q.back_offset  <= ets_pkg::BackOffsetRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        ets_pkg::RegThreshold:   cfg_q.threshold    <= pwdata[ets_pkg::SampleW-1:0];
        ets_pkg::RegFallingEdge: cfg_q.falling_edge <= pwdata[0];
        ets_pkg::RegBackOffset:  cfg_q.back_offset  <= pwdata[ets_pkg::OffsetW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (paddr[3:2])
      ets_pkg::RegThreshold:   prdata = 32'(cfg_q.threshold);
      ets_pkg::RegFallingEdge: prdata = 32'(cfg_q.falling_edge);
      ets_pkg::RegBackOffset:  prdata = 32'(cfg_q.back_offset);
      default:                 prdata = '0;
    endcase
  end

  ets_store #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_sample_i (s_axis_tdata[ets_pkg::SampleW-1:0]),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_data_o   (rd_data),
    .latest_o    (latest)
  );

  ets_scan #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (s_axis_tvalid),
    .in_command_i    (s_axis_tuser),
    .in_ready_o      (s_axis_tready),
    .wr_en_o         (wr_en),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .latest_i        (latest),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_index_o     (out_index),
    .out_not_found_o (m_axis_tuser)
  );

  assign m_axis_tdata = 16'(out_index);

endmodule
